// ===== design/tscc_pkg.sv =====
`default_nettype none

package tscc_pkg;

  // field widths fixed by the item format
  localparam int ActW   = 2;
  localparam int IdxW   = 10;
  localparam int DataW  = 32;
  localparam int CntW   = 11;

  // entry count after reset
  localparam logic [CntW-1:0] CountReset = 11'd1024;

  // item action codes
  typedef enum logic [ActW-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_LINEAR = 2'd1,
    ACT_BINARY = 2'd2
  } action_e;

endpackage

`default_nettype wire

// ===== design/tscc_ram.sv =====
`default_nettype none

module tscc_ram import tscc_pkg::*; #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== design/table_search_comparison_count_top.sv =====
// Table search with comparison count.
// Input channel (in_valid_i / in_ready_o) carries one item: action_i selects
// a load (entry_value_i written at entry_index_i, no result), a linear search
// or a binary search for target_i. Action code 3 is taken and dropped.
// Output channel (out_valid_o / out_ready_i) returns comparisons_o, the number
// of table reads a search made before a hit or before running out.
// cfg_we_i writes cfg_wdata_i into the entry count; counts above TABLE_DEPTH
// act as TABLE_DEPTH. Write it only while no search is in flight.
// A load is written to the table as it is accepted. A linear search makes one
// probe a cycle. Each binary probe passes a read state and a compare state,
// as each probe waits for its read before the bounds move. A search over zero
// entries reports 0.
// The next item is accepted once the search is handed to the output
// register; a waiting result holds the input back only once the following
// search has finished.
// All of this is set by the single read port of the table memory.
// Reset clears the control and sets the entry count to 1024; the table is
// not cleared, and entries must be loaded before they are searched.
// A stalled receiver holds comparisons_o; a finished search then waits.
`default_nettype none

module table_search_comparison_count_top import tscc_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CntW-1:0]         cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [ActW-1:0]         action_i,
  input  wire logic [IdxW-1:0]         entry_index_i,
  input  wire logic signed [DataW-1:0] entry_value_i,
  input  wire logic signed [DataW-1:0] target_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [CntW-1:0]              comparisons_o
);

  localparam int AddrW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LIN     = 3'd1;
  localparam logic [2:0] S_BIN_RD  = 3'd2;
  localparam logic [2:0] S_BIN_CMP = 3'd3;
  localparam logic [2:0] S_HOLD    = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        active_cnt;
  logic [CntW-1:0]        probes_q, probes_d;
  logic [CntW-1:0]        probe_nxt;
  logic [DataW-1:0]       key_q, key_d;
  logic signed [CntW:0]   lo_q, lo_d, hi_q, hi_d;
  logic signed [CntW:0]   lo_up, hi_dn;
  logic signed [CntW+1:0] bsum;
  logic [CntW-1:0]        mid_q, mid_d;
  logic [CntW-1:0]        rd_addr;
  logic                   wr_en;
  logic [DataW-1:0]       rd_data;
  logic                   out_load;
  logic                   slot_free;
  logic                   out_valid_q;
  logic [CntW-1:0]        out_cnt_q;

  // table memory
  tscc_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrW'(entry_index_i)),
    .wr_data_i (entry_value_i),
    .rd_addr_i (AddrW'(rd_addr)),
    .rd_data_o (rd_data)
  );

  // entries in use, clamped to the table depth
  always_comb begin
    if (32'(count_q) > TABLE_DEPTH) begin
      active_cnt = CntW'(TABLE_DEPTH);
    end else begin
      active_cnt = count_q;
    end
  end

  // helper arithmetic for probes and bounds
  assign probe_nxt = probes_q + CntW'(1);
  assign bsum      = {lo_q[CntW], lo_q} + {hi_q[CntW], hi_q};
  assign lo_up     = $signed({1'b0, mid_q}) + (CntW+1)'(1);
  assign hi_dn     = $signed({1'b0, mid_q}) - (CntW+1)'(1);
  assign slot_free = !out_valid_q || out_ready_i;

  // search sequencer
  always_comb begin
    state_d    = state_q;
    probes_d   = probes_q;
    key_d      = key_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    rd_addr    = '0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            ACT_LOAD: begin
              wr_en = (32'(entry_index_i) < TABLE_DEPTH);
            end
            ACT_LINEAR: begin
              key_d    = target_i;
              probes_d = '0;
              state_d  = (active_cnt == '0) ? S_HOLD : S_LIN;
            end
            ACT_BINARY: begin
              key_d    = target_i;
              probes_d = '0;
              lo_d     = '0;
              hi_d     = $signed({1'b0, active_cnt}) - (CntW+1)'(1);
              state_d  = (active_cnt == '0) ? S_HOLD : S_BIN_RD;
            end
            default: ;
          endcase
        end
      end
      S_LIN: begin
        // data for entry probes_q is back, next entry already requested
        probes_d = probe_nxt;
        rd_addr  = probe_nxt;
        if (rd_data == key_q || probe_nxt == active_cnt) begin
          state_d = S_HOLD;
        end
      end
      S_BIN_RD: begin
        mid_d    = bsum[CntW:1];
        rd_addr  = bsum[CntW:1];
        probes_d = probe_nxt;
        state_d  = S_BIN_CMP;
      end
      S_BIN_CMP: begin
        if (rd_data == key_q) begin
          state_d = S_HOLD;
        end else if ($signed(rd_data) < $signed(key_q)) begin
          lo_d    = lo_up;
          state_d = (lo_up > hi_q) ? S_HOLD : S_BIN_RD;
        end else begin
          hi_d    = hi_dn;
          state_d = (lo_q > hi_dn) ? S_HOLD : S_BIN_RD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    probes_q <= probes_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    if (out_load) begin
      out_cnt_q <= probes_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign comparisons_o = out_cnt_q;

  // a linear scan never runs past the entries in use
  a_lin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIN |-> probes_q < active_cnt)
    else $error("linear scan beyond entry count");

  // a binary probe is only issued on uncrossed, non-negative bounds
  a_bin_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BIN_RD |-> (lo_q <= hi_q) && (lo_q >= 0))
    else $error("binary probe on crossed bounds");

  // a search over no entries reports zero probes
  a_empty_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && active_cnt == '0 &&
     (action_i == ACT_LINEAR || action_i == ACT_BINARY))
    |=> state_q == S_HOLD && probes_q == '0)
    else $error("empty search reported probes");

  // a delivered count never exceeds the entries in use
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> probes_q <= active_cnt)
    else $error("comparison count above entry count");

endmodule

`default_nettype wire

// ===== tb/table_search_comparison_count_top_test.sv =====
`default_nettype none

module table_search_comparison_count_top_test import tscc_pkg::*;;

  localparam int Depth       = 1024;
  localparam int RandomItems = 580;
  localparam int HoldCycles  = 300;

  localparam logic [ActW-1:0]         ActUnused = 2'd3;
  localparam logic signed [DataW-1:0] MinWord   = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] MaxWord   = 32'sh7fff_ffff;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [CntW-1:0]         cfg_wdata   = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [ActW-1:0]         action      = ACT_LOAD;
  logic [IdxW-1:0]         entry_index = '0;
  logic signed [DataW-1:0] entry_value = '0;
  logic signed [DataW-1:0] target      = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic [CntW-1:0]         comparisons;

  // shadow copy of the block state
  logic signed [DataW-1:0] shadow_table [Depth];
  logic [CntW-1:0]         shadow_count = CountReset;
  logic [CntW-1:0]         pending_counts [$];

  int fault_count = 0;
  bit tx_idle_en  = 1'b0;
  bit rx_idle_en  = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_stall    = 0;

  table_search_comparison_count_top #(
    .TABLE_DEPTH(Depth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .entry_index_i(entry_index),
    .entry_value_i(entry_value),
    .target_i     (target),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .comparisons_o(comparisons)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, sometimes short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic int live_entries();
    int n;
    n = int'(shadow_count);
    if (n > Depth) n = Depth;
    return n;
  endfunction

  // probes of a scan from entry 0 up to the first equal entry
  function automatic logic [CntW-1:0] linear_probes(logic signed [DataW-1:0] key);
    int n;
    int k;
    n = live_entries();
    k = 0;
    for (int i = 0; i < n; i++) begin
      k++;
      if (shadow_table[i] == key) break;
    end
    return CntW'(k);
  endfunction

  // probes of a bisection between low and high bounds
  function automatic logic [CntW-1:0] binary_probes(logic signed [DataW-1:0] key);
    int lo;
    int hi;
    int mid;
    int k;
    lo = 0;
    hi = live_entries() - 1;
    k = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      k++;
      if (shadow_table[mid] == key) break;
      if (shadow_table[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return CntW'(k);
  endfunction

  // offer one item and hold it until taken, then update the shadow state
  task automatic send_item(input logic [ActW-1:0] act, input logic [IdxW-1:0] idx,
                           input logic signed [DataW-1:0] val,
                           input logic signed [DataW-1:0] key);
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    entry_index <= idx;
    entry_value <= val;
    target      <= key;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (act)
      ACT_LOAD:   shadow_table[idx] = val;
      ACT_LINEAR: pending_counts.push_back(linear_probes(key));
      ACT_BINARY: pending_counts.push_back(binary_probes(key));
      default: ;
    endcase
  endtask

  task automatic tx_gap();
    int n;
    if (!tx_idle_en) return;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic load_entry(input logic [IdxW-1:0] idx, input logic signed [DataW-1:0] val);
    send_item(ACT_LOAD, idx, val, DataW'($urandom));
    tx_gap();
  endtask

  task automatic search(input logic [ActW-1:0] act, input logic signed [DataW-1:0] key);
    send_item(act, IdxW'($urandom), DataW'($urandom), key);
    tx_gap();
  endtask

  // sender pause until every result is in and a trailing load is written
  task automatic wait_for_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [CntW-1:0] n);
    wait_for_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_count = n;
  endtask

  // receiver pacing, with a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall    = HoldCycles;
    end else if (rx_stall == 0 && rx_idle_en) begin
      rx_stall = pick_gap();
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [CntW-1:0] want;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_counts.size() == 0) begin
        if (fault_count < 10) $display("unexpected result: comparisons %0d", comparisons);
        fault_count++;
      end else begin
        want = pending_counts.pop_front();
        if (comparisons !== want) begin
          if (fault_count < 10)
            $display("mismatch: comparisons expected %0d got %0d", want, comparisons);
          fault_count++;
        end
      end
    end
  end

  // whole table, ascending from the most negative to the most positive value
  task automatic test_full_table();
    logic signed [DataW-1:0] v;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      v = (i == Depth - 1) ? MaxWord : DataW'(32'h8000_0000 + i * 32'h0040_0000);
      load_entry(IdxW'(i), v);
    end
    // entry count still at its reset value here
    search(ACT_LINEAR, MaxWord);
    search(ACT_LINEAR, 32'sd1);
    search(ACT_LINEAR, MinWord);
    search(ACT_BINARY, MinWord);
    search(ACT_BINARY, MaxWord);
    search(ACT_BINARY, 32'sd1);
    search(ACT_BINARY, shadow_table[300]);
    // counts above the depth act as the depth
    write_entry_count(11'd2047);
    search(ACT_BINARY, shadow_table[700]);
    search(ACT_LINEAR, 32'sd1);
    write_entry_count(11'd1025);
    search(ACT_LINEAR, shadow_table[1023]);
  endtask

  // empty, single and two-entry ranges
  task automatic test_count_limits();
    write_entry_count(11'd0);
    search(ACT_LINEAR, shadow_table[0]);
    search(ACT_BINARY, shadow_table[0]);
    write_entry_count(11'd1);
    search(ACT_LINEAR, shadow_table[0]);
    search(ACT_BINARY, 32'sd7);
    write_entry_count(11'd2);
    search(ACT_BINARY, shadow_table[1]);
    search(ACT_LINEAR, 32'sd7);
  endtask

  // unused action code must leave the table alone
  task automatic test_unused_code();
    write_entry_count(11'd4);
    send_item(ActUnused, 10'd2, 32'sh1234_5678, 32'sh1234_5678);
    send_item(ActUnused, '1, '1, '1);
    search(ACT_LINEAR, 32'sh1234_5678);
    search(ACT_LINEAR, -32'sd1);
  endtask

  // bisection on a descending table still runs to an end
  task automatic test_unsorted_binary();
    logic signed [DataW-1:0] vals [7];
    vals = '{MaxWord, 32'sd1000, 32'sd5, 32'sd0, -32'sd5, -32'sd1000, MinWord};
    write_entry_count(11'd7);
    for (int i = 0; i < 7; i++) load_entry(IdxW'(i), vals[i]);
    search(ACT_BINARY, vals[0]);
    search(ACT_BINARY, vals[3]);
    search(ACT_BINARY, vals[6]);
    search(ACT_BINARY, 32'sd7);
    search(ACT_LINEAR, vals[6]);
  endtask

  // equal entries: the scan stops at the first one
  task automatic test_duplicates();
    write_entry_count(11'd3);
    for (int i = 0; i < 3; i++) load_entry(IdxW'(i), 32'sd42);
    search(ACT_LINEAR, 32'sd42);
    search(ACT_BINARY, 32'sd42);
    search(ACT_BINARY, 32'sd43);
  endtask

  // receiver holds off while searches keep coming, so the input backs up
  task automatic test_result_backlog();
    write_entry_count(11'd16);
    for (int i = 0; i < 16; i++) load_entry(IdxW'(i), DataW'(i * 1000 - 7000));
    rx_hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      search((i % 2 == 1) ? ACT_BINARY : ACT_LINEAR, shadow_table[i * 2]);
    wait_for_quiet();
  endtask

  // random phases: set an entry count, load a fresh prefix for small ranges, then search with mixed targets
  task automatic test_random_traffic();
    int                      sent;
    int                      n;
    int                      m;
    int                      r;
    int                      smax;
    longint                  base;
    longint                  span;
    bit                      unsorted;
    bit                      top_max;
    logic signed [DataW-1:0] v;
    logic signed [DataW-1:0] key;
    logic [ActW-1:0]         act;
    sent = 0;
    while (sent < RandomItems) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        case ($urandom_range(0, 3))
          0:       n = 1024;
          1:       n = 2047;
          2:       n = 1025;
          default: n = $urandom_range(512, 1023);
        endcase
      end else if (r == 1) begin
        n = $urandom_range(0, 2);
      end else begin
        n = $urandom_range(3, 40);
      end
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      write_entry_count(CntW'(n));
      m = (n > Depth) ? Depth : n;

      // fresh prefix for small ranges, mostly ascending
      if (m <= 64) begin
        case ($urandom_range(0, 3))
          0:       smax = 2;
          1:       smax = 1000;
          2:       smax = 1 << 20;
          default: smax = 1 << 26;
        endcase
        span     = 64'd4294967295 - longint'(m) * smax;
        base     = longint'(MinWord) + (longint'($urandom) % (span + 1));
        unsorted = ($urandom_range(0, 5) == 0);
        top_max  = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 7) == 0) base = longint'(MinWord);
        for (int i = 0; i < m; i++) begin
          v = unsorted ? DataW'($urandom) : DataW'(base);
          if (top_max && i == m - 1) v = MaxWord;
          load_entry(IdxW'(i), v);
          base += longint'($urandom_range(0, smax));
          sent++;
        end
      end

      repeat ($urandom_range(8, 20)) begin
        r   = $urandom_range(0, 99);
        act = ($urandom_range(0, 1) == 1) ? ACT_LINEAR : ACT_BINARY;
        if (r < 85) begin
          if (r >= 80) begin
            key = ($urandom_range(0, 1) == 1) ? MinWord : MaxWord;
          end else if (r >= 70 || m == 0) begin
            key = DataW'($urandom);
          end else begin
            key = shadow_table[$urandom_range(0, m - 1)];
            // near misses just beside a stored value
            if (r >= 45) key = ($urandom_range(0, 1) == 1) ? key + 32'sd1 : key - 32'sd1;
          end
          search(act, key);
          sent++;
        end else if (r < 93) begin
          load_entry(IdxW'($urandom), DataW'($urandom));
          sent++;
        end else begin
          send_item(ActUnused, IdxW'($urandom), DataW'($urandom), DataW'($urandom));
          tx_gap();
        end
      end
    end
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_full_table();
    test_count_limits();
    test_unused_code();
    test_unsorted_binary();
    test_duplicates();
    test_result_backlog();
    test_random_traffic();
    wait_for_quiet();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("table_search_comparison_count_top regression: pass");
    end else begin
      $display("table_search_comparison_count_top regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("table_search_comparison_count_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
